// ===== sv/wellner_adaptive_threshold_unit_assert.svh =====
// assertion macros for the adaptive threshold unit
`ifndef WELLNER_ADAPTIVE_THRESHOLD_UNIT_ASSERT_SVH
`define WELLNER_ADAPTIVE_THRESHOLD_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define WAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wat: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define WAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wat: next-cycle check failed");

`endif

// ===== sv/wat_pkg.sv =====
// shared types and constants of the adaptive threshold unit
`timescale 1ns / 1ps

package wat_pkg;

    // fixed field widths
    localparam int SUM_W   = 24;
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 12;
    localparam int THR_W   = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // default parameter values
    localparam int MAX_WIDTH_DEF     = 2048;
    localparam int FRACTION_BITS_DEF = 8;

    // algorithm constants
    localparam int INIT_LEVEL   = 127;
    localparam int PERCENT_FULL = 100;
    localparam int LHS_SCALE    = 200;
    localparam int WINDOW_SHIFT = 3;
    localparam int MIN_WIDTH    = 8;

    // quotient bits produced per divider cycle
    localparam int DIV_STEP = 4;

    // register reset values
    localparam int RESET_IMAGE_WIDTH = 512;
    localparam int RESET_THRESHOLD   = 15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SUM,
        ST_MUL,
        ST_OUT
    } t_state;

endpackage

// ===== sv/wat_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module wat_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/wellner_adaptive_threshold_unit.sv =====
// top level of the adaptive threshold unit: sequencer, shared divider and multiplier
`timescale 1ns / 1ps

// wellner adaptive threshold over a serpentine pixel stream (even rows left to
// right, odd rows right to left). each request carries one 8-bit gray pixel and
// a frame-start flag and yields one bw bit: 1 when the pixel is at or above the
// scaled local mean formed from a decaying running sum g (window s = width/8)
// and the sum stored for the same column one row up. the first row of a frame
// uses 127*s in place of the row store. sums are unsigned fixed point with
// FRACTION_BITS fraction bits, held in 24 bits and saturated.
// a request is taken only in idle, and a new one only after the last has gone
// through set-up, the division g/s, sum update, the shared multiplier and
// result hand-over, which waits while the output side stalls. the division
// runs in a shared restoring divider that yields 4 quotient bits a cycle.
// o_stall is high from the accepting edge until the sequencer is back in
// idle. the previous result may still wait in the output register while
// the next request is taken.
// the row store is a single ram of MAX_WIDTH entries, read once per pixel at
// set-up and written once per pixel; it needs no clearing pass after reset.
// configuration: index 0 image_width (clamped to 8..MAX_WIDTH), index 1
// threshold_percent (above 100 acts as 100); write only while idle.

`include "wellner_adaptive_threshold_unit_assert.svh"

module wellner_adaptive_threshold_unit #(
    parameter int MAX_WIDTH     = wat_pkg::MAX_WIDTH_DEF,
    parameter int FRACTION_BITS = wat_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [wat_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_frame_start,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_bw,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [wat_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wat_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int SumW     = wat_pkg::SUM_W;
    localparam int PixW     = wat_pkg::PIX_W;
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int ColW     = $clog2(MAX_WIDTH);
    localparam int SW       = $clog2((MAX_WIDTH >> wat_pkg::WINDOW_SHIFT) + 1);
    // 127 needs 7 bits
    localparam int InitRawW = SW + 7 + FRACTION_BITS;
    localparam int InitW    = (InitRawW > SumW) ? InitRawW : SumW + 1;
    localparam int MulAW    = SumW + 1;
    // pixel * 200 stays below 2^16
    localparam int MulBW    = 16;
    localparam int MulW     = MulAW + MulBW;
    localparam int LhsW     = MulW + FRACTION_BITS;
    localparam int NewW     = SumW + 2;
    localparam int DivIters = SumW / wat_pkg::DIV_STEP;
    localparam int CntW     = (DivIters > 1) ? $clog2(DivIters) : 1;
    localparam longint ResetSumRaw =
        (longint'(wat_pkg::INIT_LEVEL)
         * longint'(wat_pkg::RESET_IMAGE_WIDTH >> wat_pkg::WINDOW_SHIFT)) << FRACTION_BITS;
    localparam logic [SumW-1:0] ResetSum =
        (ResetSumRaw > longint'(wat_pkg::SUM_MAX)) ? wat_pkg::SUM_MAX : SumW'(ResetSumRaw);

    // sequencer
    wat_pkg::t_state r_state;
    wat_pkg::t_state n_state;

    // configuration
    logic [wat_pkg::CFG_W-1:0] r_image_width;
    logic [wat_pkg::THR_W-1:0] r_threshold;

    // scan state
    logic [SumW-1:0] r_sum;
    logic [ColW-1:0] r_col;
    logic            r_rtl;
    logic            r_first;

    // captured request
    logic [PixW-1:0]  r_pixel;
    logic [MulBW-1:0] r_p200;
    logic             r_fs;

    // divider: dividend shifts out at the top, quotient shifts in at the bottom
    logic [SumW-1:0] r_dq;
    logic [SW-1:0]   r_rem;
    logic [CntW-1:0] r_cnt;

    // multiplier results
    logic [MulW-1:0] r_lhs;
    logic [MulW-1:0] r_rhs;

    // output register
    logic r_out_valid;
    logic r_bw;

    // combinational
    logic [WW-1:0]           w_eff;
    logic [SW-1:0]           s;
    logic [InitW-1:0]        init_wide;
    logic [SumW-1:0]         init_sum;
    logic [wat_pkg::THR_W-1:0] thr_k;
    logic [ColW-1:0]         prep_col;
    logic                    col_last;
    logic [NewW-1:0]         new_wide;
    logic [SumW-1:0]         new_sum;
    logic [SumW-1:0]         prev;
    logic [SumW-1:0]         ram_rd_data;
    logic [MulAW-1:0]        mul_a;
    logic [MulBW-1:0]        mul_b;
    logic [MulW-1:0]         mul_p;
    logic [SumW-1:0]         div_dq;
    logic [SW-1:0]           div_rem;
    logic [LhsW-1:0]         lhs_full;
    logic                    in_accept;
    logic                    out_free;

    // sequencer outputs
    logic busy;
    logic ram_rd_en;
    logic ram_wr_en;
    logic mul_sel_rhs;
    logic out_load;

    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;

    // effective width and window length
    always_comb begin
        if (r_image_width < wat_pkg::CFG_W'(wat_pkg::MIN_WIDTH)) begin
            w_eff = WW'(wat_pkg::MIN_WIDTH);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_image_width);
        end
    end

    assign s = SW'(w_eff >> wat_pkg::WINDOW_SHIFT);

    // starting level 127*s, saturated
    assign init_wide = (InitW'(s) << 7) - InitW'(s);
    always_comb begin
        if ((init_wide << FRACTION_BITS) > InitW'(wat_pkg::SUM_MAX)) begin
            init_sum = wat_pkg::SUM_MAX;
        end else begin
            init_sum = SumW'(init_wide << FRACTION_BITS);
        end
    end

    // 100 - t, with t clamped at 100
    assign thr_k = (r_threshold > wat_pkg::THR_W'(wat_pkg::PERCENT_FULL)) ? '0
                 : wat_pkg::THR_W'(wat_pkg::PERCENT_FULL) - r_threshold;

    // column after frame restart and after a width shrink
    always_comb begin
        if (r_fs) begin
            prep_col = '0;
        end else if (WW'(r_col) >= w_eff) begin
            prep_col = ColW'(w_eff - WW'(1));
        end else begin
            prep_col = r_col;
        end
    end

    assign col_last = (WW'(r_col) == w_eff - WW'(1));

    // running sum update, r_dq holds the quotient g/s here
    assign new_wide = (NewW'(r_pixel) << FRACTION_BITS) + NewW'(r_sum) - NewW'(r_dq);
    assign new_sum  = (new_wide > NewW'(wat_pkg::SUM_MAX)) ? wat_pkg::SUM_MAX
                    : SumW'(new_wide);

    assign prev = r_first ? init_sum : ram_rd_data;

    // shared multiplier: s * p*200 at set-up, (100-t) * (g + prev) later
    assign mul_a = mul_sel_rhs ? (MulAW'(r_sum) + MulAW'(prev)) : MulAW'(s);
    assign mul_b = mul_sel_rhs ? MulBW'(thr_k) : r_p200;
    assign mul_p = MulW'(mul_a) * MulW'(mul_b);

    assign lhs_full = LhsW'(r_lhs) << FRACTION_BITS;

    // restoring divider, several quotient bits a cycle
    always_comb begin
        logic [SW:0] trial;
        trial   = '0;
        div_dq  = r_dq;
        div_rem = r_rem;
        for (int k = 0; k < wat_pkg::DIV_STEP; k++) begin
            trial  = {div_rem, div_dq[SumW-1]};
            div_dq = {div_dq[SumW-2:0], 1'b0};
            if (trial >= {1'b0, s}) begin
                trial     = trial - {1'b0, s};
                div_dq[0] = 1'b1;
            end
            div_rem = trial[SW-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wat_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = wat_pkg::ST_PREP;
                end
            end
            wat_pkg::ST_PREP: n_state = wat_pkg::ST_DIV;
            wat_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = wat_pkg::ST_SUM;
                end
            end
            wat_pkg::ST_SUM:  n_state = wat_pkg::ST_MUL;
            wat_pkg::ST_MUL:  n_state = wat_pkg::ST_OUT;
            wat_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = wat_pkg::ST_IDLE;
                end
            end
            default: n_state = wat_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        busy        = 1'b1;
        ram_rd_en   = 1'b0;
        ram_wr_en   = 1'b0;
        mul_sel_rhs = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            wat_pkg::ST_IDLE: busy = 1'b0;
            wat_pkg::ST_PREP: ram_rd_en = 1'b1;
            wat_pkg::ST_DIV:  ;
            wat_pkg::ST_SUM:  ;
            wat_pkg::ST_MUL: begin
                ram_wr_en   = 1'b1;
                mul_sel_rhs = 1'b1;
            end
            wat_pkg::ST_OUT:  out_load = out_free;
            default:          ;
        endcase
    end

    assign o_stall = busy;

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= wat_pkg::ST_IDLE;
            r_image_width <= wat_pkg::CFG_W'(wat_pkg::RESET_IMAGE_WIDTH);
            r_threshold   <= wat_pkg::THR_W'(wat_pkg::RESET_THRESHOLD);
            r_sum         <= ResetSum;
            r_col         <= '0;
            r_rtl         <= 1'b0;
            r_first       <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    wat_pkg::CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data;
                    wat_pkg::CFG_THRESHOLD:   r_threshold <= i_cfg_data[wat_pkg::THR_W-1:0];
                    default:                  ;
                endcase
            end

            case (r_state)
                wat_pkg::ST_PREP: begin
                    // frame start restarts the scan before this pixel
                    r_col <= prep_col;
                    if (r_fs) begin
                        r_sum   <= init_sum;
                        r_rtl   <= 1'b0;
                        r_first <= 1'b1;
                    end
                end
                wat_pkg::ST_SUM: r_sum <= new_sum;
                wat_pkg::ST_MUL: begin
                    // serpentine step, direction flips at a row end
                    if (r_rtl) begin
                        if (r_col == '0) begin
                            r_rtl   <= 1'b0;
                            r_first <= 1'b0;
                        end else begin
                            r_col <= r_col - ColW'(1);
                        end
                    end else begin
                        if (col_last) begin
                            r_rtl   <= 1'b1;
                            r_first <= 1'b0;
                        end else begin
                            r_col <= r_col + ColW'(1);
                        end
                    end
                end
                default: ;
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pixel <= i_pixel;
            r_fs    <= i_frame_start;
            r_p200  <= MulBW'(i_pixel) * MulBW'(wat_pkg::LHS_SCALE);
        end
        case (r_state)
            wat_pkg::ST_PREP: begin
                r_dq  <= r_fs ? init_sum : r_sum;
                r_rem <= '0;
                r_cnt <= CntW'(DivIters - 1);
                r_lhs <= mul_p;
            end
            wat_pkg::ST_DIV: begin
                r_dq  <= div_dq;
                r_rem <= div_rem;
                r_cnt <= r_cnt - CntW'(1);
            end
            wat_pkg::ST_MUL: r_rhs <= mul_p;
            default: ;
        endcase
        if (out_load) begin
            r_bw <= (lhs_full >= LhsW'(r_rhs));
        end
    end

    // row store of sums from the previous row
    wat_ram #(
        .WIDTH(SumW),
        .DEPTH(MAX_WIDTH)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_col),
        .i_wr_data (r_sum),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (prep_col),
        .o_rd_data (ram_rd_data)
    );

    assign o_valid = r_out_valid;
    assign o_bw    = r_bw;

    // a taken request moves straight into set-up and blocks the next one
    `WAT_ASSERT_NEXT(a_accept_prep, i_clk, i_rst_n, in_accept, (r_state == wat_pkg::ST_PREP) && o_stall)
    // divider remainder always stays below the divisor
    `WAT_ASSERT_NOW(a_rem_bound, i_clk, i_rst_n, r_state == wat_pkg::ST_DIV, r_rem < s)
    // the row store is written only inside the active row
    `WAT_ASSERT_NOW(a_col_bound, i_clk, i_rst_n, ram_wr_en, WW'(r_col) < w_eff)
    // a result hand-over leaves a valid output and an idle sequencer
    `WAT_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, out_load, o_valid && !o_stall)

endmodule

// ===== tb/wellner_adaptive_threshold_unit_test.sv =====
// self-checking bench for the adaptive threshold unit: directed and random pixel streams
`timescale 1ns / 1ps

module wellner_adaptive_threshold_unit_test;

    // field widths of the block
    localparam int PIX_W     = wat_pkg::PIX_W;
    localparam int CFG_W     = wat_pkg::CFG_W;
    localparam int CFG_IDX_W = wat_pkg::CFG_IDX_W;
    localparam int THR_W     = wat_pkg::THR_W;
    localparam int SUM_W     = wat_pkg::SUM_W;
    localparam logic [SUM_W-1:0] SUM_MAX = wat_pkg::SUM_MAX;

    // fixed point and algorithm constants of the thresholding rule
    localparam int FRAC         = wat_pkg::FRACTION_BITS_DEF;
    localparam int START_GAIN   = 127;
    localparam int LHS_GAIN     = 200;
    localparam int FULL_PERCENT = 100;
    localparam int NARROWEST    = 8;
    localparam int WIDEST       = wat_pkg::MAX_WIDTH_DEF;

    // cycles with no handshake on either side before the run is abandoned
    localparam int IDLE_LIMIT = 4000;
    // length of the forced output hold-off, and the result count that starts it
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT     = 120;
    localparam int MAX_REPORTS = 20;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_pixel_req;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    // block inputs, all known from time zero
    logic                 i_valid       = 1'b0;
    logic [PIX_W-1:0]     i_pixel       = '0;
    logic                 i_frame_start = 1'b0;
    logic                 i_stall       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = wat_pkg::CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    logic o_stall;
    logic o_valid;
    logic o_bw;

    wellner_adaptive_threshold_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_bw          (o_bw),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // pixel requests still to be offered, and bw bits owed by the block
    t_pixel_req pixel_queue [$];
    logic       bw_due [$];

    // idling percentages, changed between phases
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    // bookkeeping for the summary
    int requests_taken = 0;
    int results_seen   = 0;
    int whites_seen    = 0;
    int mismatches     = 0;
    int settings_run   = 0;

    // ---------------------------------------------------------------
    // predictor: own copy of the registers and of the scan state
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] cur_width   = CFG_W'(wat_pkg::RESET_IMAGE_WIDTH);
    logic [THR_W-1:0] cur_percent = THR_W'(wat_pkg::RESET_THRESHOLD);

    logic [SUM_W-1:0] level_sum;
    logic [SUM_W-1:0] row_level [0:WIDEST-1];
    logic [10:0]      scan_col     = '0;
    logic             scan_reverse = 1'b0;
    logic             scan_top_row = 1'b1;

    // width as the block uses it, held inside 8..2048
    function automatic logic [CFG_W-1:0] clamp_width(input logic [CFG_W-1:0] w);
        if (w < NARROWEST) return CFG_W'(NARROWEST);
        if (w > WIDEST) return CFG_W'(WIDEST);
        return w;
    endfunction

    // 127 * s in fixed point, saturated to the sum width
    function automatic logic [SUM_W-1:0] start_level(input logic [CFG_W-1:0] s);
        logic [63:0] v;
        v = (64'(s) * START_GAIN) << FRAC;
        return (v > 64'(SUM_MAX)) ? SUM_MAX : v[SUM_W-1:0];
    endfunction

    // works out the bw bit of one accepted request and advances the scan
    task automatic threshold_pixel(input logic [PIX_W-1:0] px, input logic fs);
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] s;
        logic [THR_W-1:0] pct;
        logic [63:0]      acc;
        logic [63:0]      lhs;
        logic [63:0]      rhs;
        logic [SUM_W-1:0] above;
        w   = clamp_width(cur_width);
        s   = w >> 3;
        pct = (cur_percent > FULL_PERCENT) ? THR_W'(FULL_PERCENT) : cur_percent;
        if (fs) begin
            level_sum    = start_level(s);
            scan_col     = '0;
            scan_reverse = 1'b0;
            scan_top_row = 1'b1;
        end
        // width shrunk in mid frame: pull the column back inside the row
        if (CFG_W'(scan_col) >= w) scan_col = 11'(w - 1);

        acc = (64'(px) << FRAC) + 64'(level_sum) - 64'(level_sum) / 64'(s);
        level_sum = (acc > 64'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];

        // first row of a frame has nothing above it
        above = scan_top_row ? start_level(s) : row_level[scan_col];
        lhs   = ((64'(px) * LHS_GAIN) * 64'(s)) << FRAC;
        rhs   = 64'(FULL_PERCENT - int'(pct)) * (64'(level_sum) + 64'(above));
        bw_due.push_back(lhs >= rhs);

        row_level[scan_col] = level_sum;

        // serpentine walk: column holds at a row end while direction flips
        if (scan_reverse) begin
            if (scan_col == 0) begin
                scan_reverse = 1'b0;
                scan_top_row = 1'b0;
            end else begin
                scan_col = scan_col - 1'b1;
            end
        end else begin
            if (CFG_W'(scan_col) == w - 1'b1) begin
                scan_reverse = 1'b1;
                scan_top_row = 1'b0;
            end else begin
                scan_col = scan_col + 1'b1;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // driver: offers queued requests, payload held while stalled
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel_req req;
        logic       taken;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            taken = i_valid && !o_stall;
            if (taken) begin
                threshold_pixel(i_pixel, i_frame_start);
                requests_taken++;
            end
            // only move on once the current request is gone
            if (!i_valid || taken) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    req = pixel_queue.pop_front();
                    i_valid       <= 1'b1;
                    i_pixel       <= req.pixel;
                    i_frame_start <= req.frame_start;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks each result against the oldest owed bw bit
    // ---------------------------------------------------------------
    int hold_left = 0;

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (o_bw) whites_seen++;
                if (bw_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with no request pending, expected none, actual %0b",
                                 $time, o_bw);
                end else begin
                    want = bw_due.pop_front();
                    if (o_bw !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: bw mismatch, expected %0b, actual %0b",
                                     $time, want, o_bw);
                    end
                end
                // long hold-off once, so the block fills and backs up its input
                if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < receiver_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: cycles with no handshake on either channel
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results still owed",
                         $time, quiet_cycles, bw_due.size());
                $display("wellner_adaptive_threshold_unit_test: FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_pixel(input logic [PIX_W-1:0] px, input logic fs);
        t_pixel_req req;
        req.pixel       = px;
        req.frame_start = fs;
        pixel_queue.push_back(req);
    endtask

    // waits until every request is taken and every result is back, then lets
    // the sequencer settle so a register write lands while it is idle
    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (pixel_queue.size() != 0 || i_valid || bw_due.size() != 0 || o_stall);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == wat_pkg::CFG_IMAGE_WIDTH) cur_width = data;
        else cur_percent = data[THR_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // new setting between phases; reports whether the row got wider, since a
    // wider row must start a fresh frame or unwritten row entries get read
    task automatic set_phase(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] pct,
                             input int snd_idle, input int rcv_idle, output bit grew);
        logic [CFG_W-1:0] old_w;
        wait_until_drained();
        old_w = clamp_width(cur_width);
        write_reg(wat_pkg::CFG_IMAGE_WIDTH, width);
        write_reg(wat_pkg::CFG_THRESHOLD, pct);
        grew = clamp_width(cur_width) > old_w;
        sender_idle_pct   = snd_idle;
        receiver_idle_pct = rcv_idle;
        settings_run++;
    endtask

    // mostly a drifting gray level with random specks; occasional restarts
    task automatic queue_pixels(input int count, input bit open_frame,
                                input int restart_per_mille);
        int               level;
        logic [PIX_W-1:0] px;
        logic             fs;
        level = $urandom_range(255);
        for (int k = 0; k < count; k++) begin
            fs = (k == 0 && open_frame) || ($urandom_range(999) < restart_per_mille);
            if ($urandom_range(3) == 0) begin
                px = PIX_W'($urandom_range(255));
            end else begin
                level = level + int'($urandom_range(40)) - 20;
                if (level < 0) level = 0;
                if (level > 255) level = 255;
                px = PIX_W'(level);
            end
            push_pixel(px, fs);
        end
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        bit grew;
        level_sum = start_level(CFG_W'(wat_pkg::RESET_IMAGE_WIDTH) >> 3);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        settings_run = 1;

        // reset setting: extreme pixels, restart in mid frame
        sender_idle_pct   = 22;
        receiver_idle_pct = 75;
        push_pixel(8'd255, 1'b1);
        push_pixel(8'd0,   1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd128, 1'b0);
        push_pixel(8'd0,   1'b1);
        push_pixel(8'd255, 1'b0);

        // narrowest row, zero threshold: row end, turn-around, reads of the row store
        set_phase(CFG_W'(NARROWEST), '0, 22, 75, grew);
        push_pixel(8'd255, 1'b1);
        for (int k = 1; k < 12; k++) push_pixel((k % 3 == 0) ? 8'd0 : 8'd200, 1'b0);

        // threshold above 100 and exactly 100: every pixel white
        set_phase(CFG_W'(NARROWEST), CFG_W'(127), 22, 75, grew);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd1, 1'b0);
        set_phase(CFG_W'(NARROWEST), CFG_W'(FULL_PERCENT), 22, 75, grew);
        push_pixel(8'd0, 1'b0);

        // random phases: sender idles little and receiver much, then the
        // reverse, then no idling at all
        set_phase(CFG_W'(16), CFG_W'(15), 22, 75, grew);
        queue_pixels(250, 1'b1, 8);

        // narrower in mid frame, no opening restart
        set_phase(CFG_W'(9), CFG_W'(40), 22, 75, grew);
        queue_pixels(150, grew, 5);

        // all width bits set, clamped to the widest row
        set_phase(CFG_W'(4095), CFG_W'(60), 75, 22, grew);
        queue_pixels(150, 1'b1, 0);

        // width zero, clamped to eight: column lies far beyond the new row
        set_phase('0, CFG_W'(85), 75, 22, grew);
        queue_pixels(200, grew, 10);

        // widest row, zero threshold, first stretch of a fresh frame
        set_phase(CFG_W'(WIDEST), '0, 0, 0, grew);
        queue_pixels(120, 1'b1, 0);

        // shrink below the current column of a wide row
        set_phase(CFG_W'(100), CFG_W'(15), 0, 0, grew);
        queue_pixels(200, grew, 8);

        wait_until_drained();
        repeat (20) @(posedge i_clk);

        $display("covered %0d pixel requests under %0d register settings, %0d results checked",
                 requests_taken, settings_run, results_seen);
        $display("%0d white and %0d black results, %0d mismatches",
                 whites_seen, results_seen - whites_seen, mismatches);
        if (mismatches == 0 && bw_due.size() == 0) begin
            $display("wellner_adaptive_threshold_unit_test: PASS");
        end else begin
            $display("wellner_adaptive_threshold_unit_test: FAIL");
        end
        $finish;
    end

endmodule
